// File: rtl/core/pcl_pkg.sv
// ----------------------------------------------------------------------------
// pcl_pkg
// Types and codes shared by the positional character list.
// ----------------------------------------------------------------------------
package pcl_pkg;

   // Command codes carried in the request
   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_GET    = 2'd2,
      CMD_PRINT  = 2'd3
   } cmd_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_GET     = 3'd0,
      ST_ELEM    = 3'd1,
      ST_EMPTY   = 3'd2,
      ST_INVALID = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] position;
      logic [7:0] elem;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [7:0] value;
      logic       last;
   } rsp_type;

endpackage

// File: rtl/core/positional_char_list.sv
// ----------------------------------------------------------------------------
// positional_char_list
// Ordered byte list with 1-based insert, delete, get and print, kept in one
// single-port-per-direction memory and moved one element at a time.
// ----------------------------------------------------------------------------
//
//  channel   ports                        transfer when
//  --------  ---------------------------  ----------------------------------
//  request   start, busy, req_payload     start high and busy low at edge
//  result    rsp_strobe, rsp_payload      every edge that ends a strobe cycle
//
//  Steps: after the transfer busy stays high while add alternates S_ADD and
//  S_ADD_WR, delete S_DEL and S_DEL_WR, print S_PRD and S_PEM, and get
//  passes S_GET; each element moved or printed takes a memory read state
//  and a write or emit state on the single storage array.
//  Invalid position, list full and empty print answer in the cycle after
//  the transfer and leave busy low.
//  Reset clears the count and the sequencer; the storage is left as is.
//  The result side has no back pressure: each result shows for one cycle.
//
module positional_char_list
   import pcl_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   // Index into the store and count (which must reach CAPACITY itself)
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,      // issue read of the element below, or drop in the new one
      S_ADD_WR,   // write the element one place up
      S_DEL,      // issue read of the element above, or finish
      S_DEL_WR,   // write the element one place down
      S_GET,      // read data ready, answer
      S_PRD,      // issue read of the next element to print
      S_PEM       // emit that element
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] ptr_ff;
   logic [CNT_W-1:0] stop_ff;
   logic [7:0]       elem_ff;
   logic             rsp_strobe_ff;
   rsp_type          rsp_ff;

   // Storage
   logic [7:0]       mem [CAPACITY];
   logic [7:0]       rd_data_ff;
   logic [CNT_W-1:0] rd_ptr_in;
   logic             we_in;
   logic [CNT_W-1:0] wr_ptr_in;
   logic [7:0]       wr_data_in;

   // Request decode
   logic             accept;
   logic [8:0]       pos_ext;
   logic [8:0]       cnt_ext;
   logic             pos_zero;
   logic             pos_ok_add;
   logic             pos_ok_rd;
   logic             full;
   logic [CNT_W-1:0] pos_cnt;
   logic [CNT_W-1:0] ptr_dec;
   logic [CNT_W-1:0] ptr_inc;

   assign accept     = start && (state_ff == S_IDLE);
   assign busy       = (state_ff != S_IDLE);
   assign pos_ext    = {1'b0, req_payload.position};
   assign cnt_ext    = 9'(count_ff);
   assign pos_zero   = (req_payload.position == 8'd0);
   assign pos_ok_add = !pos_zero && (pos_ext <= cnt_ext + 9'd1);
   assign pos_ok_rd  = !pos_zero && (pos_ext <= cnt_ext);
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign pos_cnt    = CNT_W'(req_payload.position);
   assign ptr_dec    = ptr_ff - 1'b1;
   assign ptr_inc    = ptr_ff + 1'b1;

   // Read address and write port driven by the sequencer
   always_comb begin
      rd_ptr_in  = ptr_ff;
      we_in      = 1'b0;
      wr_ptr_in  = ptr_ff;
      wr_data_in = rd_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            rd_ptr_in = pos_cnt - 1'b1;
         end
         S_ADD: begin
            rd_ptr_in = ptr_dec;
            if (ptr_ff == stop_ff) begin
               we_in      = 1'b1;
               wr_data_in = elem_ff;
            end
         end
         S_ADD_WR: begin
            we_in = 1'b1;
         end
         S_DEL_WR: begin
            we_in     = 1'b1;
            wr_ptr_in = ptr_dec;
         end
         S_DEL, S_GET, S_PRD, S_PEM: begin
            rd_ptr_in = ptr_ff;
         end
         default: begin
            rd_ptr_in = ptr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we_in) begin
         mem[wr_ptr_in[IDX_W-1:0]] <= wr_data_in;
      end
      rd_data_ff <= mem[rd_ptr_in[IDX_W-1:0]];
   end

   // Sequencer and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         ptr_ff        <= '0;
         stop_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  elem_ff <= req_payload.elem;
                  unique case (req_payload.cmd)
                     CMD_ADD: begin
                        if (!pos_ok_add) begin
                           rsp_strobe_ff <= 1'b1;
                           rsp_ff        <= '{ST_INVALID, 8'd0, 1'b1};
                        end else if (full) begin
                           rsp_strobe_ff <= 1'b1;
                           rsp_ff        <= '{ST_FULL, 8'd0, 1'b1};
                        end else begin
                           // walk down from the old end to the insert slot
                           ptr_ff   <= count_ff;
                           stop_ff  <= pos_cnt - 1'b1;
                           state_ff <= S_ADD;
                        end
                     end
                     CMD_DELETE: begin
                        if (!pos_ok_rd) begin
                           rsp_strobe_ff <= 1'b1;
                           rsp_ff        <= '{ST_INVALID, 8'd0, 1'b1};
                        end else begin
                           ptr_ff   <= pos_cnt;
                           state_ff <= S_DEL;
                        end
                     end
                     CMD_GET: begin
                        if (!pos_ok_rd) begin
                           rsp_strobe_ff <= 1'b1;
                           rsp_ff        <= '{ST_INVALID, 8'd0, 1'b1};
                        end else begin
                           state_ff <= S_GET;
                        end
                     end
                     CMD_PRINT: begin
                        if (count_ff == '0) begin
                           rsp_strobe_ff <= 1'b1;
                           rsp_ff        <= '{ST_EMPTY, 8'd0, 1'b1};
                        end else begin
                           ptr_ff   <= '0;
                           state_ff <= S_PRD;
                        end
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_ADD: begin
               if (ptr_ff == stop_ff) begin
                  count_ff <= count_ff + 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_ADD_WR;
               end
            end
            S_ADD_WR: begin
               ptr_ff   <= ptr_dec;
               state_ff <= S_ADD;
            end
            S_DEL: begin
               if (ptr_ff == count_ff) begin
                  count_ff <= count_ff - 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_DEL_WR;
               end
            end
            S_DEL_WR: begin
               ptr_ff   <= ptr_inc;
               state_ff <= S_DEL;
            end
            S_GET: begin
               rsp_strobe_ff <= 1'b1;
               rsp_ff        <= '{ST_GET, rd_data_ff, 1'b1};
               state_ff      <= S_IDLE;
            end
            S_PRD: begin
               state_ff <= S_PEM;
            end
            S_PEM: begin
               rsp_strobe_ff <= 1'b1;
               rsp_ff        <= '{ST_ELEM, rd_data_ff, (ptr_inc == count_ff)};
               if (ptr_inc == count_ff) begin
                  state_ff <= S_IDLE;
               end else begin
                  ptr_ff   <= ptr_inc;
                  state_ff <= S_PRD;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   // The element count never passes the store size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("count exceeds capacity");

   // Moving elements never produces a result
   a_shift_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD || state_ff == S_ADD_WR ||
       state_ff == S_DEL || state_ff == S_DEL_WR) |=> !rsp_strobe_ff)
      else $error("result during shift");

   // A print result without the last mark leaves the block still printing
   a_print_more: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_payload.last) |-> busy)
      else $error("print stream ended without last mark");

   // A get either answers at once with an error or goes on to read
   a_get_progress: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.cmd == CMD_GET) |=> (busy || rsp_strobe))
      else $error("get accepted with no progress");

endmodule
